// File: rtl/b64u_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, constants and the character map for the base64url encoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] POS_EMPTY = 2'd0;
  localparam logic [1:0] POS_ONE   = 2'd1;
  localparam logic [1:0] POS_TWO   = 2'd2;

  // Group handed from the front to the back: 24-bit chunk, MSB first,
  // and the index of the last sextet to emit (1..3).
  typedef struct packed {
    logic [23:0] chunk;
    logic [1:0]  last_idx;
  } grp_t;

  // URL-safe alphabet: A-Z, a-z, 0-9, '-', '_'
  function automatic logic [7:0] b64u_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h00;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2d;
    end else begin
      c = 8'h5f;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/b64u_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_front
// Collects input bytes into groups and pushes full or message-ending groups.
// ----------------------------------------------------------------------------
module b64u_front
  import b64u_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_eom,
  output logic            in_ready,
  output logic            push_valid,
  output grp_t            push_data,
  input  wire logic       push_ready
);

  logic [15:0] pending_r, pending_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [1:0]  pos;
  logic        take;

  assign in_ready = push_ready;
  assign take     = in_valid && push_ready;
  // unused position 3 behaves as empty
  assign pos      = (pos_r == 2'd3) ? POS_EMPTY : pos_r;

  always_comb begin
    pending_nxt         = pending_r;
    pos_nxt             = pos_r;
    push_valid          = 1'b0;
    push_data.chunk     = 24'd0;
    push_data.last_idx  = 2'd3;
    unique case (pos)
      POS_EMPTY: begin
        push_data.chunk    = {in_byte, 16'd0};
        push_data.last_idx = 2'd1;
        push_valid         = in_valid && in_eom;
      end
      POS_ONE: begin
        push_data.chunk    = {pending_r[15:8], in_byte, 8'd0};
        push_data.last_idx = 2'd2;
        push_valid         = in_valid && in_eom;
      end
      default: begin
        push_data.chunk    = {pending_r, in_byte};
        push_data.last_idx = 2'd3;
        push_valid         = in_valid;
      end
    endcase
    if (take) begin
      if (push_valid) begin
        pending_nxt = 16'd0;
        pos_nxt     = POS_EMPTY;
      end else if (pos == POS_EMPTY) begin
        pending_nxt = {in_byte, 8'd0};
        pos_nxt     = POS_ONE;
      end else begin
        pending_nxt = {pending_r[15:8], in_byte};
        pos_nxt     = POS_TWO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 16'd0;
      pos_r     <= POS_EMPTY;
    end else begin
      pending_r <= pending_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/b64u_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_fifo
// Short group queue between front and back.
// ----------------------------------------------------------------------------
module b64u_fifo
  import b64u_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  input  wire grp_t wr_data,
  output logic      wr_ready,
  output logic      rd_valid,
  output grp_t      rd_data,
  input  wire logic rd_ready
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  grp_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          wr_en, rd_en;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointer gap");
`endif

endmodule
`default_nettype wire

// File: rtl/b64u_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_back
// Takes groups off the queue and sends one character per transfer.
// ----------------------------------------------------------------------------
module b64u_back
  import b64u_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       grp_valid,
  input  wire grp_t       grp_data,
  output logic            grp_ready,
  output logic            out_valid,
  output logic [7:0]      out_char,
  output logic            out_last,
  input  wire logic       out_ready
);

  logic       busy_r, busy_nxt;
  grp_t       ent_r, ent_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       oval_r, oval_nxt;
  logic [7:0] ochar_r, ochar_nxt;
  logic       olast_r, olast_nxt;
  logic       out_free, emit, is_last;
  logic [5:0] sextet;

  assign out_free  = !oval_r || out_ready;
  assign emit      = busy_r && out_free;
  assign is_last   = (idx_r == ent_r.last_idx);
  assign grp_ready = !busy_r || (emit && is_last);

  always_comb begin
    unique case (idx_r)
      2'd0:    sextet = ent_r.chunk[23:18];
      2'd1:    sextet = ent_r.chunk[17:12];
      2'd2:    sextet = ent_r.chunk[11:6];
      default: sextet = ent_r.chunk[5:0];
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    ent_nxt   = ent_r;
    idx_nxt   = idx_r;
    oval_nxt  = oval_r;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    if (emit) begin
      oval_nxt  = 1'b1;
      ochar_nxt = b64u_char(sextet);
      olast_nxt = is_last;
      idx_nxt   = idx_r + 1'b1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
    if (grp_valid && grp_ready) begin
      busy_nxt = 1'b1;
      ent_nxt  = grp_data;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      oval_r <= oval_nxt;
    end
    ent_r   <= ent_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid = oval_r;
  assign out_char  = ochar_r;
  assign out_last  = olast_r;

`ifndef SYNTHESIS
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(oval_r) |-> $past(busy_r))
    else $error("character sent with no group loaded");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= ent_r.last_idx))
    else $error("sextet index past end of group");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last && !grp_valid) |=> !busy_r)
    else $error("group still busy after its last character");
`endif

endmodule
`default_nettype wire

// File: rtl/base64url_encoder.sv
`default_nettype none
// Path: a byte that closes a group or a message goes through the group queue,
//   the group register and the output register of the back end to out_tvalid.
// Throughput: one input byte per cycle while the group queue has room; the
//   output register sends one character per cycle while out_tready is high,
//   so a steady stream's rate is set by the single character path of the back end.
// Reset: synchronous rst_n clears the pending group, the queue and out_tvalid.
// ----------------------------------------------------------------------------
// base64url_encoder
// Streaming unpadded base64url encoder: bytes in, URL-safe characters out.
// ----------------------------------------------------------------------------
module base64url_encoder
  import b64u_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // end_of_message
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast   // last_char
);

  // front -> queue
  logic push_valid, push_ready;
  grp_t push_data;
  // queue -> back
  logic pop_valid, pop_ready;
  grp_t pop_data;

  // Front: tracks group position and the two held bytes; a transfer that
  // completes a group or ends a message pushes the whole chunk.
  b64u_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_eom     (in_tlast),
    .in_ready   (in_tready),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // Queue decouples byte intake from character output.
  b64u_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_data  (push_data),
    .wr_ready (push_ready),
    .rd_valid (pop_valid),
    .rd_data  (pop_data),
    .rd_ready (pop_ready)
  );

  // Back: walks the sextets of one group, maps each to ASCII and drives the
  // registered output; tlast marks the final character of the group.
  b64u_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (pop_valid),
    .grp_data  (pop_data),
    .grp_ready (pop_ready),
    .out_valid (out_tvalid),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

endmodule
`default_nettype wire
